// ===== rtl/barometric_pressure_compensation_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BPC_NEVER(lbl, cond, msg) `BPC_ASSERT(lbl, !(cond), msg)
`else
`define BPC_ASSERT(lbl, prop, msg)
`define BPC_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register map and word types of the pressure compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

   localparam int RAW_W      = 24;
   localparam int Q_W        = 24;
   localparam int DIV_STEPS  = 25;
   localparam int DIV_HI_W   = 23;
   localparam int WIDE_W     = 48;
   localparam int MUL_SPLIT  = 24;
   localparam int TEMP_W     = 21;
   localparam int PRES_W     = 32;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;
   localparam int TEMP_READY_BIT = 5;
   localparam int PRES_READY_BIT = 4;

   localparam logic [RAW_W-1:0] SCALE_RESET = 24'd7864320;

   typedef enum logic [2:0] {
      REG_C0_C1      = 3'd0,
      REG_C00_C10    = 3'd1,
      REG_C01_C11    = 3'd2,
      REG_C20_C21    = 3'd3,
      REG_C30        = 3'd4,
      REG_TEMP_SCALE = 3'd5,
      REG_PRES_SCALE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [11:0] c0;
      logic [11:0] c1;
      logic [19:0] c00;
      logic [19:0] c10;
      logic [15:0] c01;
      logic [15:0] c11;
      logic [15:0] c20;
      logic [15:0] c21;
      logic [15:0] c30;
   } calib_type;

   typedef struct packed {
      logic [Q_W-1:0] psc;
      logic [Q_W-1:0] tsc;
   } work_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider: signed raw reading over unsigned scale into a
// saturated Q1.23 fraction, rounded to nearest, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_vld,
   input  wire logic [bpc_pkg::RAW_W-1:0]  raw,
   input  wire logic [bpc_pkg::RAW_W-1:0]  scale,
   output logic                            out_vld,
   output logic [bpc_pkg::Q_W-1:0]         quot
);

   localparam int STEPS = bpc_pkg::DIV_STEPS;
   localparam int RW    = bpc_pkg::RAW_W;
   localparam logic [STEPS-1:0] Q_ONE = STEPS'(1) << (bpc_pkg::Q_W - 1);

   logic              neg_w;
   logic [RW-1:0]     mag_w;
   logic [RW-1:0]     div_w;
   logic [2*RW-1:0]   num_w;
   logic              ovf_w;

   logic [STEPS:0]    vld_ff;
   logic [STEPS:0]    neg_ff;
   logic [STEPS:0]    ovf_ff;
   logic [RW-1:0]     rem_ff [0:STEPS];
   logic [STEPS-1:0]  low_ff [0:STEPS];
   logic [RW-1:0]     div_ff [0:STEPS];

   logic [RW:0]       trial_w [0:STEPS-1];
   logic [RW+1:0]     diff_w  [0:STEPS-1];
   logic [RW-1:0]     rem_in  [1:STEPS];
   logic [STEPS-1:0]  low_in  [1:STEPS];

   logic [STEPS-1:0]  qlim_w;
   logic [RW-1:0]     quot_in;
   logic [RW-1:0]     quot_ff;
   logic              out_vld_ff;

   // dividend = |raw| * 2^23 + scale/2; top bits already >= scale means overflow
   always_comb begin
      neg_w = raw[RW-1];
      mag_w = neg_w ? (~raw + RW'(1)) : raw;
      div_w = (scale == '0) ? RW'(1) : scale;
      num_w = {1'b0, mag_w, {bpc_pkg::DIV_HI_W{1'b0}}} + (2*RW)'(div_w >> 1);
      ovf_w = ({1'b0, num_w[2*RW-1:STEPS]} >= div_w);
   end

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         trial_w[k]  = {rem_ff[k], low_ff[k][STEPS-1]};
         diff_w[k]   = {1'b0, trial_w[k]} - {2'b00, div_ff[k]};
         rem_in[k+1] = diff_w[k][RW+1] ? trial_w[k][RW-1:0] : diff_w[k][RW-1:0];
         low_in[k+1] = {low_ff[k][STEPS-2:0], ~diff_w[k][RW+1]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= {1'b0, num_w[2*RW-1:STEPS]};
      low_ff[0] <= num_w[STEPS-1:0];
      div_ff[0] <= div_w;
      neg_ff[0] <= neg_w;
      ovf_ff[0] <= ovf_w;
      for (int k = 1; k <= STEPS; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_in[k];
         div_ff[k] <= div_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   // clamp to [-1, 1 - 2^-23]
   always_comb begin
      if (neg_ff[STEPS]) begin
         qlim_w  = (ovf_ff[STEPS] || (low_ff[STEPS] > Q_ONE)) ? Q_ONE : low_ff[STEPS];
         quot_in = ~qlim_w[RW-1:0] + RW'(1);
      end else begin
         qlim_w  = (ovf_ff[STEPS] || (low_ff[STEPS] > (Q_ONE - STEPS'(1))))
                   ? (Q_ONE - STEPS'(1)) : low_ff[STEPS];
         quot_in = qlim_w[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[STEPS-1:0], in_vld};
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   assign out_vld = out_vld_ff;
   assign quot    = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Takes readings, drops those with neither ready bit, scales the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [7:0]                 status_byte,
   input  wire logic [bpc_pkg::RAW_W-1:0]  pres_reading,
   input  wire logic [bpc_pkg::RAW_W-1:0]  temp_reading,
   input  wire logic [bpc_pkg::RAW_W-1:0]  pres_scale,
   input  wire logic [bpc_pkg::RAW_W-1:0]  temp_scale,
   output logic                            push,
   output bpc_pkg::work_type               push_word
);

   logic                    keep_w;
   logic                    pres_vld;
   logic                    temp_vld;
   logic [bpc_pkg::Q_W-1:0] psc_w;
   logic [bpc_pkg::Q_W-1:0] tsc_w;

   assign keep_w = start && !busy && (status_byte[bpc_pkg::TEMP_READY_BIT] ||
                                      status_byte[bpc_pkg::PRES_READY_BIT]);

   bpc_div u_pres_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (keep_w),
      .raw     (pres_reading),
      .scale   (pres_scale),
      .out_vld (pres_vld),
      .quot    (psc_w)
   );

   bpc_div u_temp_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (keep_w),
      .raw     (temp_reading),
      .scale   (temp_scale),
      .out_vld (temp_vld),
      .quot    (tsc_w)
   );

   always_comb begin
      push          = pres_vld && temp_vld;
      push_word.psc = psc_w;
      push_word.tsc = tsc_w;
   end

endmodule

`default_nettype wire

// ===== rtl/bpc_fifo.sv =====
// ----------------------------------------------------------------------------
// bpc_fifo
// Two-word queue between the scaling front and the polynomial back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "barometric_pressure_compensation_top_assert.svh"

module bpc_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire bpc_pkg::work_type    push_word,
   input  wire logic                 pop,
   output bpc_pkg::work_type         pop_word,
   output bpc_pkg::queue_status_type status
);

   bpc_pkg::work_type                mem_ff [0:bpc_pkg::QUEUE_DEPTH-1];
   logic [bpc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [bpc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [bpc_pkg::QUEUE_CNT_W-1:0]  cnt_ff;
   logic [bpc_pkg::QUEUE_CNT_W-1:0]  cnt_in;
   logic                             do_push;
   logic                             do_pop;

   always_comb begin
      status.empty = (cnt_ff == '0);
      status.full  = (cnt_ff == bpc_pkg::QUEUE_CNT_W'(bpc_pkg::QUEUE_DEPTH));
      do_push      = push && (!status.full || pop);
      do_pop       = pop && !status.empty;
      cnt_in       = cnt_ff + bpc_pkg::QUEUE_CNT_W'(do_push) - bpc_pkg::QUEUE_CNT_W'(do_pop);
      pop_word     = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   `BPC_NEVER(a_no_overflow, push && status.full && !pop, "word pushed into full queue")
   `BPC_ASSERT(a_push_lands, (push && !pop) |=> !status.empty, "pushed word not held")
   `BPC_ASSERT(a_pop_frees, (pop && !push && (cnt_ff == 1)) |=> status.empty, "last pop left data")

endmodule

`default_nettype wire

// ===== rtl/bpc_mulq.sv =====
// ----------------------------------------------------------------------------
// bpc_mulq
// Q23 fraction times wide Q23 value, rounded back to Q23; two split partial
// products in one stage, recombined and rounded in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_mulq (
   input  wire logic                        clock,
   input  wire logic [bpc_pkg::Q_W-1:0]     x,
   input  wire logic [bpc_pkg::WIDE_W-1:0]  y,
   output logic [bpc_pkg::WIDE_W-1:0]       r
);

   localparam int XW = bpc_pkg::Q_W;
   localparam int YW = bpc_pkg::WIDE_W;
   localparam int SP = bpc_pkg::MUL_SPLIT;
   localparam int FW = XW + YW;

   logic signed [XW+YW-SP-1:0] ph_ff;
   logic signed [XW+SP:0]      pl_ff;
   logic signed [FW-1:0]       full_w;
   logic [YW-1:0]              r_ff;

   always_ff @(posedge clock) begin
      ph_ff <= $signed(x) * $signed(y[YW-1:SP]);
      pl_ff <= $signed(x) * $signed({1'b0, y[SP-1:0]});
      r_ff  <= full_w[YW+bpc_pkg::Q_W-2:bpc_pkg::Q_W-1];
   end

   // add half an LSB of Q23, then floor shift by 23
   assign full_w = ($signed(ph_ff) <<< SP) + $signed(pl_ff)
                 + (FW'(1) <<< (bpc_pkg::Q_W - 2));
   assign r = r_ff;

endmodule

`default_nettype wire

// ===== rtl/bpc_back.sv =====
// ----------------------------------------------------------------------------
// bpc_back
// Compensation polynomials on scaled readings; fixed-latency pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        take,
   input  wire bpc_pkg::work_type           word,
   input  wire bpc_pkg::calib_type          cal,
   output logic                             rsp_valid,
   output logic [bpc_pkg::TEMP_W-1:0]       rsp_temp_out,
   output logic [bpc_pkg::PRES_W-1:0]       rsp_pres_out
);

   localparam int QW = bpc_pkg::Q_W;
   localparam int WW = bpc_pkg::WIDE_W;
   localparam int TW = bpc_pkg::TEMP_W;
   localparam int NST = 8;

   logic [NST-1:0]          vld_ff;
   logic signed [39:0]      m30_ff, m21_ff;
   logic signed [35:0]      mt_ff;
   logic [QW-1:0]           psc1_ff, tsc1_ff, psc2_ff, tsc2_ff;
   logic [QW-1:0]           tsc3_ff, tsc4_ff, psc3_ff, psc4_ff, psc5_ff, tsc5_ff;
   logic signed [WW-1:0]    a2_ff, d2_ff, b5_ff, f5_ff, psum8_ff;
   logic [TW-1:0]           temp2_ff, temp3_ff, temp4_ff, temp5_ff;
   logic [TW-1:0]           temp6_ff, temp7_ff, temp8_ff;
   logic [WW-1:0]           qa_w, qd_w, pp_w, gg_w;

   logic signed [36:0]      tsum_w;
   logic signed [21:0]      trnd_w;
   logic [TW-1:0]           temp_in;
   logic signed [WW-1:0]    a_in, d_in, b_in, f_in, psum_in, prnd_w;

   logic                    rsp_valid_ff;
   logic [TW-1:0]           rsp_temp_ff;
   logic [bpc_pkg::PRES_W-1:0] rsp_pres_ff;

   always_comb begin
      a_in   = ($signed(cal.c20) <<< (QW - 1)) + m30_ff;
      d_in   = ($signed(cal.c11) <<< (QW - 1)) + m21_ff;
      // c0/2 + c1*Tsc in Q23, rounded to 1/256 degC
      tsum_w = ($signed(cal.c0) <<< (QW - 2)) + mt_ff + 37'sd16384;
      trnd_w = $signed(tsum_w[36:15]);
      if (trnd_w > 22'sd1048575) begin
         temp_in = {1'b0, {(TW-1){1'b1}}};
      end else if (trnd_w < -22'sd1048576) begin
         temp_in = {1'b1, {(TW-1){1'b0}}};
      end else begin
         temp_in = trnd_w[TW-1:0];
      end
      b_in    = ($signed(cal.c10) <<< (QW - 1)) + $signed(qa_w);
      f_in    = ($signed(cal.c01) <<< (QW - 1)) + $signed(qd_w);
      psum_in = ($signed(cal.c00) <<< (QW - 1)) + $signed(pp_w) + $signed(gg_w);
      prnd_w  = (psum8_ff + 48'sd65536) >>> 17;
   end

   bpc_mulq u_mul_a (.clock(clock), .x(psc2_ff), .y(a2_ff), .r(qa_w));
   bpc_mulq u_mul_d (.clock(clock), .x(psc2_ff), .y(d2_ff), .r(qd_w));
   bpc_mulq u_mul_b (.clock(clock), .x(psc5_ff), .y(b5_ff), .r(pp_w));
   bpc_mulq u_mul_f (.clock(clock), .x(tsc5_ff), .y(f5_ff), .r(gg_w));

   always_ff @(posedge clock) begin
      m30_ff   <= $signed(cal.c30) * $signed(word.psc);
      m21_ff   <= $signed(cal.c21) * $signed(word.psc);
      mt_ff    <= $signed(cal.c1) * $signed(word.tsc);
      psc1_ff  <= word.psc;
      tsc1_ff  <= word.tsc;
      a2_ff    <= a_in;
      d2_ff    <= d_in;
      temp2_ff <= temp_in;
      psc2_ff  <= psc1_ff;
      tsc2_ff  <= tsc1_ff;
      psc3_ff  <= psc2_ff;
      tsc3_ff  <= tsc2_ff;
      temp3_ff <= temp2_ff;
      psc4_ff  <= psc3_ff;
      tsc4_ff  <= tsc3_ff;
      temp4_ff <= temp3_ff;
      b5_ff    <= b_in;
      f5_ff    <= f_in;
      psc5_ff  <= psc4_ff;
      tsc5_ff  <= tsc4_ff;
      temp5_ff <= temp4_ff;
      temp6_ff <= temp5_ff;
      temp7_ff <= temp6_ff;
      psum8_ff <= psum_in;
      temp8_ff <= temp7_ff;
      rsp_temp_ff <= temp8_ff;
      // |sum| stays below 2^46, so the 1/64 Pa value always fits 32 bits
      rsp_pres_ff <= prnd_w[bpc_pkg::PRES_W-1:0];
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[NST-2:0], take};
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_temp_out = rsp_temp_ff;
   assign rsp_pres_out = rsp_pres_ff;

endmodule

`default_nettype wire

// ===== rtl/barometric_pressure_compensation_top.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Pressure and temperature compensation from raw readings and calibration.
// ----------------------------------------------------------------------------
// A reading is taken on any clock with start high and busy low, one per
// cycle. Readings with neither ready bit set produce nothing; every other
// one produces exactly one result, flagged by rsp_valid for a single cycle,
// in the order the readings were taken. The pipeline holds the two
// 25-step pipelined dividers that scale the readings and the two rounds of
// split multiplies in the polynomial; the result side cannot be stalled and
// must take every word as it comes. Calibration and scale registers sit on
// the APB port and must only be written while no reading is in flight.
`default_nettype none

module barometric_pressure_compensation_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [7:0]                       req_status_byte,
   input  wire logic [bpc_pkg::RAW_W-1:0]        req_pres_reading,
   input  wire logic [bpc_pkg::RAW_W-1:0]        req_temp_reading,
   output logic                                  rsp_valid,
   output logic [bpc_pkg::TEMP_W-1:0]            rsp_temp_out,
   output logic [bpc_pkg::PRES_W-1:0]            rsp_pres_out,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [bpc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [bpc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bpc_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);

   localparam int DW = bpc_pkg::CSR_DATA_W;

   logic [23:0]                c0_c1_ff;
   logic [39:0]                c00_c10_ff;
   logic [31:0]                c01_c11_ff;
   logic [31:0]                c20_c21_ff;
   logic [15:0]                c30_ff;
   logic [bpc_pkg::RAW_W-1:0]  temp_scale_ff;
   logic [bpc_pkg::RAW_W-1:0]  pres_scale_ff;

   bpc_pkg::reg_index_type     csr_index;
   logic                       csr_write;
   bpc_pkg::calib_type         cal;
   bpc_pkg::work_type          push_word;
   bpc_pkg::work_type          pop_word;
   bpc_pkg::queue_status_type  q_status;
   logic                       push;
   logic                       take;

   assign csr_index = bpc_pkg::reg_index_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_c1_ff      <= '0;
         c00_c10_ff    <= '0;
         c01_c11_ff    <= '0;
         c20_c21_ff    <= '0;
         c30_ff        <= '0;
         temp_scale_ff <= bpc_pkg::SCALE_RESET;
         pres_scale_ff <= bpc_pkg::SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bpc_pkg::REG_C0_C1:      c0_c1_ff      <= pwdata[23:0];
            bpc_pkg::REG_C00_C10:    c00_c10_ff    <= pwdata[39:0];
            bpc_pkg::REG_C01_C11:    c01_c11_ff    <= pwdata[31:0];
            bpc_pkg::REG_C20_C21:    c20_c21_ff    <= pwdata[31:0];
            bpc_pkg::REG_C30:        c30_ff        <= pwdata[15:0];
            bpc_pkg::REG_TEMP_SCALE: temp_scale_ff <= pwdata[23:0];
            bpc_pkg::REG_PRES_SCALE: pres_scale_ff <= pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bpc_pkg::REG_C0_C1:      prdata = DW'(c0_c1_ff);
         bpc_pkg::REG_C00_C10:    prdata = DW'(c00_c10_ff);
         bpc_pkg::REG_C01_C11:    prdata = DW'(c01_c11_ff);
         bpc_pkg::REG_C20_C21:    prdata = DW'(c20_c21_ff);
         bpc_pkg::REG_C30:        prdata = DW'(c30_ff);
         bpc_pkg::REG_TEMP_SCALE: prdata = DW'(temp_scale_ff);
         bpc_pkg::REG_PRES_SCALE: prdata = DW'(pres_scale_ff);
         default:                 prdata = '0;
      endcase
   end

   always_comb begin
      cal.c0  = c0_c1_ff[23:12];
      cal.c1  = c0_c1_ff[11:0];
      cal.c00 = c00_c10_ff[39:20];
      cal.c10 = c00_c10_ff[19:0];
      cal.c01 = c01_c11_ff[31:16];
      cal.c11 = c01_c11_ff[15:0];
      cal.c20 = c20_c21_ff[31:16];
      cal.c21 = c20_c21_ff[15:0];
      cal.c30 = c30_ff;
   end

   // back end drains one word every cycle, so the queue never backs up
   assign busy = q_status.full;
   assign take = !q_status.empty;

   bpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .status_byte  (req_status_byte),
      .pres_reading (req_pres_reading),
      .temp_reading (req_temp_reading),
      .pres_scale   (pres_scale_ff),
      .temp_scale   (temp_scale_ff),
      .push         (push),
      .push_word    (push_word)
   );

   bpc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (take),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   bpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .word         (pop_word),
      .cal          (cal),
      .rsp_valid    (rsp_valid),
      .rsp_temp_out (rsp_temp_out),
      .rsp_pres_out (rsp_pres_out)
   );

endmodule

`default_nettype wire

// ===== test/barometric_pressure_compensation_top_test.sv =====
// ----------------------------------------------------------------------------
// Pressure compensation testbench
// Drives raw readings through the command port under several calibration and
// scale settings, predicts each compensated word and checks it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  SETTLE_CYCLES = 60;
   localparam int  CYCLE_LIMIT   = 400000;
   localparam longint Q_ONE      = 64'sd8388608;

   typedef struct packed {
      logic [bpc_pkg::TEMP_W-1:0] temp;
      logic [bpc_pkg::PRES_W-1:0] pres;
   } reading_type;

   class compensation_board;
      logic [63:0] regs [7];
      reading_type pending_q [$];
      int errors;
      int checked;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[bpc_pkg::REG_TEMP_SCALE] = bpc_pkg::SCALE_RESET;
         regs[bpc_pkg::REG_PRES_SCALE] = bpc_pkg::SCALE_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(bpc_pkg::reg_index_type idx, logic [63:0] val);
         case (idx)
            bpc_pkg::REG_C00_C10: regs[idx] = val & 64'hFF_FFFF_FFFF;
            bpc_pkg::REG_C01_C11, bpc_pkg::REG_C20_C21: regs[idx] = val & 64'hFFFF_FFFF;
            bpc_pkg::REG_C30: regs[idx] = val & 64'hFFFF;
            default: regs[idx] = val & 64'hFF_FFFF;
         endcase
      endfunction

      function longint sx(longint v, int bits);
         return (v <<< (64 - bits)) >>> (64 - bits);
      endfunction

      // Q23 product rounded back to Q23, split to keep products in 64 bits
      function longint mul_q23(longint x, longint y);
         longint yh, yl;
         yh = y >>> 23;
         yl = y - (yh <<< 23);
         return x * yh + ((x * yl + 64'sd4194304) >>> 23);
      endfunction

      function longint scale_q23(logic [23:0] raw, logic [63:0] scale);
         longint v, s, mag, q;
         v = sx(longint'(raw), 24);
         s = longint'(scale[23:0]);
         if (s == 0) s = 1;
         mag = (v < 0 ? -v : v) <<< 23;
         q = (mag + s / 2) / s;
         if (v < 0) return (q > Q_ONE) ? -Q_ONE : -q;
         return (q > Q_ONE - 1) ? Q_ONE - 1 : q;
      endfunction

      function longint clamp(longint v, int bits);
         longint hi, lo;
         hi = (64'sd1 <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void note(logic [7:0] status, logic [23:0] praw, logic [23:0] traw);
         longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
         longint psc, tsc, t, a, b, pp, d, f, g, p;
         reading_type w;
         if (!status[bpc_pkg::TEMP_READY_BIT] && !status[bpc_pkg::PRES_READY_BIT]) return;
         c0  = sx(longint'(regs[bpc_pkg::REG_C0_C1] >> 12), 12);
         c1  = sx(longint'(regs[bpc_pkg::REG_C0_C1]), 12);
         c00 = sx(longint'(regs[bpc_pkg::REG_C00_C10] >> 20), 20);
         c10 = sx(longint'(regs[bpc_pkg::REG_C00_C10]), 20);
         c01 = sx(longint'(regs[bpc_pkg::REG_C01_C11] >> 16), 16);
         c11 = sx(longint'(regs[bpc_pkg::REG_C01_C11]), 16);
         c20 = sx(longint'(regs[bpc_pkg::REG_C20_C21] >> 16), 16);
         c21 = sx(longint'(regs[bpc_pkg::REG_C20_C21]), 16);
         c30 = sx(longint'(regs[bpc_pkg::REG_C30]), 16);
         psc = scale_q23(praw, regs[bpc_pkg::REG_PRES_SCALE]);
         tsc = scale_q23(traw, regs[bpc_pkg::REG_TEMP_SCALE]);
         t = c0 * (Q_ONE / 2) + c1 * tsc;
         t = clamp((t + 64'sd16384) >>> 15, bpc_pkg::TEMP_W);
         a  = c20 * Q_ONE + c30 * psc;
         b  = c10 * Q_ONE + mul_q23(psc, a);
         pp = mul_q23(psc, b);
         d  = c11 * Q_ONE + c21 * psc;
         f  = c01 * Q_ONE + mul_q23(psc, d);
         g  = mul_q23(tsc, f);
         p  = c00 * Q_ONE + pp + g;
         p  = clamp((p + 64'sd65536) >>> 17, bpc_pkg::PRES_W);
         w.temp = t[bpc_pkg::TEMP_W-1:0];
         w.pres = p[bpc_pkg::PRES_W-1:0];
         pending_q.push_back(w);
      endfunction

      function void check(logic [bpc_pkg::TEMP_W-1:0] temp,
                          logic [bpc_pkg::PRES_W-1:0] pres);
         reading_type w;
         checked++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected word temp=%0d pres=%0d", $time,
                     $signed(temp), $signed(pres));
            errors++;
            return;
         end
         w = pending_q.pop_front();
         if (temp !== w.temp) begin
            $display("%0t: temp_out expected %0d actual %0d", $time,
                     $signed(w.temp), $signed(temp));
            errors++;
         end
         if (pres !== w.pres) begin
            $display("%0t: pres_out expected %0d actual %0d", $time,
                     $signed(w.pres), $signed(pres));
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [7:0] req_status_byte = '0;
   logic [bpc_pkg::RAW_W-1:0] req_pres_reading = '0;
   logic [bpc_pkg::RAW_W-1:0] req_temp_reading = '0;
   logic rsp_valid;
   logic [bpc_pkg::TEMP_W-1:0] rsp_temp_out;
   logic [bpc_pkg::PRES_W-1:0] rsp_pres_out;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [bpc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [bpc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [bpc_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   compensation_board board = new();
   int cycles = 0;
   int accepted = 0;
   bit quiet = 0;

   barometric_pressure_compensation_top dut (
      .clock, .reset, .start, .busy,
      .req_status_byte, .req_pres_reading, .req_temp_reading,
      .rsp_valid, .rsp_temp_out, .rsp_pres_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) begin
            accepted++;
            board.note(req_status_byte, req_pres_reading, req_temp_reading);
         end
         if (rsp_valid) board.check(rsp_temp_out, rsp_pres_out);
      end
   end

   task automatic write_reg(bpc_pkg::reg_index_type idx, logic [63:0] val);
      @(negedge clock);
      psel = 1; pwrite = 1; penable = 0;
      paddr = bpc_pkg::CSR_ADDR_W'(idx * 8);
      pwdata = val;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      board.set_reg(idx, val);
   endtask

   task automatic send(logic [7:0] st, logic [23:0] pr, logic [23:0] tr);
      @(negedge clock);
      start = 1;
      req_status_byte = st;
      req_pres_reading = pr;
      req_temp_reading = tr;
      do @(posedge clock); while (busy);
      // random gap after the word
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         start = 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // all results back, then room for readings that make no word
   task automatic drain();
      @(negedge clock);
      start = 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'hFFFFFF;
         3: return 24'($urandom_range(0, 16));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_status();
      logic [7:0] s;
      s = 8'($urandom);
      if ($urandom_range(0, 4) != 0 && !s[bpc_pkg::TEMP_READY_BIT] &&
          !s[bpc_pkg::PRES_READY_BIT])
         s[$urandom_range(0, 1) ? bpc_pkg::TEMP_READY_BIT : bpc_pkg::PRES_READY_BIT] = 1'b1;
      return s;
   endfunction

   task automatic random_config(int mode);
      logic [63:0] v [7];
      foreach (v[i]) v[i] = {$urandom, $urandom};
      case (mode)
         1: begin  // largest positive coefficients, tiny scales
            v[bpc_pkg::REG_C0_C1]      = 64'h7FF7FF;
            v[bpc_pkg::REG_C00_C10]    = 64'h7FFFF7FFFF;
            v[bpc_pkg::REG_C01_C11]    = 64'h7FFF7FFF;
            v[bpc_pkg::REG_C20_C21]    = 64'h7FFF7FFF;
            v[bpc_pkg::REG_C30]        = 64'h7FFF;
            v[bpc_pkg::REG_TEMP_SCALE] = 64'd1;
            v[bpc_pkg::REG_PRES_SCALE] = 64'd0;
         end
         2: begin  // most negative coefficients, largest scales
            v[bpc_pkg::REG_C0_C1]      = 64'h800800;
            v[bpc_pkg::REG_C00_C10]    = 64'h8000080000;
            v[bpc_pkg::REG_C01_C11]    = 64'h80008000;
            v[bpc_pkg::REG_C20_C21]    = 64'h80008000;
            v[bpc_pkg::REG_C30]        = 64'h8000;
            v[bpc_pkg::REG_TEMP_SCALE] = 64'hFFFFFF;
            v[bpc_pkg::REG_PRES_SCALE] = 64'hFFFFFF;
         end
         3: begin  // all ones
            foreach (v[i]) v[i] = '1;
         end
         default: begin
            v[bpc_pkg::REG_TEMP_SCALE] = 64'($urandom_range(24'h100000, 24'hFFFFFF));
            v[bpc_pkg::REG_PRES_SCALE] = 64'($urandom_range(24'h100000, 24'hFFFFFF));
         end
      endcase
      for (int i = 0; i < 7; i++) write_reg(bpc_pkg::reg_index_type'(i), v[i]);
   endtask

   initial begin
      logic [23:0] edges [5];
      edges = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings, then a plausible calibration
      send(8'h30, 24'h123456, 24'h654321);
      drain();
      random_config(0);
      // status patterns, including ones that make no word
      send(8'h00, 24'h7FFFFF, 24'h7FFFFF);
      send(8'hCF, 24'h000001, 24'h800000);
      send(8'h10, 24'h7FFFFF, 24'h800000);
      send(8'h20, 24'h800000, 24'h7FFFFF);
      send(8'h30, 24'hFFFFFF, 24'h000000);
      send(8'hFF, 24'h000000, 24'hFFFFFF);
      foreach (edges[i]) send(8'h30, edges[i], edges[4 - i]);
      drain();
      random_config(1);
      foreach (edges[i]) send(8'h30, edges[i], edges[i]);
      drain();
      random_config(2);
      foreach (edges[i]) send(8'h30, edges[(i + 1) % 5], edges[i]);
      drain();
      random_config(3);
      foreach (edges[i]) send(8'h30, edges[i], edges[(i + 2) % 5]);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         random_config(ph < 5 ? 0 : ph - 4);
         quiet = (ph == 7);
         for (int n = 0; n < 215; n++) send(pick_status(), pick_raw(), pick_raw());
      end

      drain();
      $display("Covered %0d readings, %0d words checked over 13 register settings",
               accepted, board.checked);
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
